/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is held.
`define DRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, ignored while reset is held.
`define DRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, checked during reset too.
`define DRT_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/drt_pkg.sv */
// Types, codes and defaults shared by the retry table modules.
`default_nettype none
package drt_pkg;

    localparam int DRT_ENTRIES    = 16;
    localparam int DRT_RECIPIENTS = 8;

    // Opcodes of an input item.
    localparam logic [1:0] OP_TRACK = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Result status codes.
    localparam logic [3:0] RS_TRACKED   = 4'd0;
    localparam logic [3:0] RS_DUPLICATE = 4'd1;
    localparam logic [3:0] RS_FULL      = 4'd2;
    localparam logic [3:0] RS_APPLIED   = 4'd3;
    localparam logic [3:0] RS_UNK_MSG   = 4'd4;
    localparam logic [3:0] RS_UNK_RCPT  = 4'd5;
    localparam logic [3:0] RS_BAD_CODE  = 4'd6;
    localparam logic [3:0] RS_ILLEGAL   = 4'd7;
    localparam logic [3:0] RS_FAILED    = 4'd8;
    localparam logic [3:0] RS_DONE      = 4'd9;

    // Recipient status codes.
    localparam logic [2:0] ST_ABSENT    = 3'd0;
    localparam logic [2:0] ST_ANNOUNCED = 3'd1;
    localparam logic [2:0] ST_PENDING   = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;
    localparam logic [2:0] ST_FAILED    = 3'd5;
    localparam logic [2:0] ST_BOUNCED   = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INIT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MULTIPLIER   = 2'd1;
    localparam logic [1:0] CFG_MAX_BACKOFF  = 2'd2;
    localparam logic [1:0] CFG_MAX_RETRIES  = 2'd3;

    localparam logic [23:0] MAX24      = 24'hFFFFFF;
    localparam logic [8:0]  RETRY_SAT  = 9'd511;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK_A,
        S_CHK_B,
        S_CHK_END
    } t_state;

    typedef enum logic [2:0] {
        C_NOP,
        C_TRACK,
        C_ACK,
        C_RETRY,
        C_EXHAUST
    } t_cell_op;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        t_cell_op    op;
        logic [15:0] key;
        logic [7:0]  slot;
        logic [7:0]  mask;
        logic [2:0]  ridx;
        logic [2:0]  new_st;
        logic        done;
        logic [8:0]  retry;
        logic [31:0] due;
        logic [23:0] backoff;
    } t_cell_cmd;

endpackage
`default_nettype wire

/* hdl/drt_cell.sv */
// One table slot: entry state plus the free-slot chain link to its neighbor.
`default_nettype none
module drt_cell import drt_pkg::*; #(
    parameter int RECIPIENTS = DRT_RECIPIENTS,
    parameter int SLOT       = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cell_cmd                    i_cmd,
    input  wire logic                         i_taken,
    output logic                              o_taken,
    output logic                              o_valid,
    output logic [15:0]                       o_key,
    output logic [RECIPIENTS-1:0][2:0]        o_status,
    output logic [8:0]                        o_retry,
    output logic [31:0]                       o_due,
    output logic [23:0]                       o_backoff
);

    logic                      r_valid;
    logic [15:0]               r_key;
    logic [RECIPIENTS-1:0][2:0] r_st;
    logic [8:0]                r_retry;
    logic [31:0]               r_due;
    logic [23:0]               r_backoff;

    logic w_take;
    logic w_match;
    logic w_here;

    // A free slot takes a new entry only if no lower slot is free.
    assign w_take  = !r_valid && !i_taken;
    assign o_taken = i_taken || !r_valid;
    assign w_match = r_valid && (r_key == i_cmd.key);
    assign w_here  = (i_cmd.slot == 8'(SLOT));

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                C_TRACK:   if (w_take) r_valid <= 1'b1;
                C_ACK:     if (w_match && i_cmd.done) r_valid <= 1'b0;
                C_EXHAUST: if (w_here) r_valid <= 1'b0;
                default:   ;
            endcase
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            C_TRACK: begin
                if (w_take) begin
                    r_key     <= i_cmd.key;
                    r_retry   <= '0;
                    r_backoff <= i_cmd.backoff;
                    r_due     <= i_cmd.due;
                    for (int i = 0; i < RECIPIENTS; i++) begin
                        if (i < 8 && i_cmd.mask[i[2:0]]) r_st[i] <= ST_ANNOUNCED;
                        else r_st[i] <= ST_ABSENT;
                    end
                end
            end
            C_ACK: begin
                if (w_match) begin
                    for (int i = 0; i < RECIPIENTS; i++) begin
                        if (i < 8 && i[2:0] == i_cmd.ridx) r_st[i] <= i_cmd.new_st;
                    end
                end
            end
            C_RETRY: begin
                if (w_here) begin
                    r_retry   <= i_cmd.retry;
                    r_backoff <= i_cmd.backoff;
                    r_due     <= i_cmd.due;
                    for (int i = 0; i < RECIPIENTS; i++) begin
                        if (r_st[i] == ST_ANNOUNCED) r_st[i] <= ST_PENDING;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid   = r_valid;
    assign o_key     = r_key;
    assign o_status  = r_st;
    assign o_retry   = r_retry;
    assign o_due     = r_due;
    assign o_backoff = r_backoff;

endmodule
`default_nettype wire

/* hdl/delivery_retry_table_top.sv */
// Delivery retry table: a row of entry cells with a shared retry and backoff controller.
//
//   channel   direction  handshake             payload
//   s_axis    in         tvalid/tready         tdata[63:0]: opcode, key, mask, index, code, now
//   m_axis    out        tvalid/tready         tdata[31:0]: status, key, failed mask, removed; tlast
//   cfg       in         write enable          index[1:0], wdata[23:0]
//
// Track and ack pass through accept, an execute state, then the result.
// Check passes through accept, an execute state, two visits per slot (one
// to form the backoff product in the shared multiplier, one to update the cell), a closing
// state, then the done result.
// Reset clears all valid flags at once; no clearing pass is needed.
// A stalled result holds the walk only where another result must be sent.
`default_nettype none
module delivery_retry_table_top import drt_pkg::*; #(
    parameter int ENTRIES    = DRT_ENTRIES,
    parameter int RECIPIENTS = DRT_RECIPIENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [1:0] opcode, [17:2] message_key, [25:18] recipient_mask,
    // [28:26] recipient_index, [31:29] ack_code, [63:32] now_ms
    input  wire logic [63:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [3:0] status, [19:4] result_key, [27:20] failed_mask, [28] entry_removed
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_wdata
);

    localparam int IDXW = $clog2(ENTRIES);

    // Configuration registers.
    logic [23:0] r_init;
    logic [4:0]  r_mult;
    logic [23:0] r_maxb;
    logic [7:0]  r_maxr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 24'd1000;
            r_mult <= 5'd2;
            r_maxb <= 24'd60000;
            r_maxr <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INIT_TIMEOUT: r_init <= i_cfg_wdata;
                CFG_MULTIPLIER:   r_mult <= i_cfg_wdata[4:0];
                CFG_MAX_BACKOFF:  r_maxb <= i_cfg_wdata;
                CFG_MAX_RETRIES:  r_maxr <= i_cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    // Control and latched item.
    t_state          r_state, n_state;
    logic [IDXW-1:0] r_idx;
    logic [1:0]      r_op;
    logic [15:0]     r_key;
    logic [7:0]      r_mask;
    logic [2:0]      r_ridx;
    logic [2:0]      r_code;
    logic [31:0]     r_now;

    // Check pipeline registers.
    logic        r_hit;
    logic        r_exh;
    logic [8:0]  r_retry_n;
    logic [28:0] r_prod;

    // Output register.
    logic        r_ov;
    logic [3:0]  r_o_status;
    logic [15:0] r_o_key;
    logic [7:0]  r_o_fm;
    logic        r_o_rm;
    logic        r_o_last;

    logic w_accept;
    logic w_out_free;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // Cell row.
    t_cell_cmd                              w_cmd;
    logic [ENTRIES:0]                       w_taken;
    logic [ENTRIES-1:0]                     w_valid;
    logic [ENTRIES-1:0][15:0]               w_key;
    logic [ENTRIES-1:0][RECIPIENTS-1:0][2:0] w_st;
    logic [ENTRIES-1:0][8:0]                w_retry;
    logic [ENTRIES-1:0][31:0]               w_due;
    logic [ENTRIES-1:0][23:0]               w_backoff;

    assign w_taken[0] = 1'b0;

    for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
        drt_cell #(
            .RECIPIENTS (RECIPIENTS),
            .SLOT       (e)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_taken   (w_taken[e]),
            .o_taken   (w_taken[e+1]),
            .o_valid   (w_valid[e]),
            .o_key     (w_key[e]),
            .o_status  (w_st[e]),
            .o_retry   (w_retry[e]),
            .o_due     (w_due[e]),
            .o_backoff (w_backoff[e])
        );
    end

    // Select one cell: the walk slot during a check, the key match otherwise.
    logic                       w_walk;
    logic                       w_found;
    logic                       s_valid;
    logic [15:0]                s_key;
    logic [RECIPIENTS-1:0][2:0] s_st;
    logic [8:0]                 s_retry;
    logic [31:0]                s_due;
    logic [23:0]                s_backoff;

    assign w_walk = (r_state == S_CHK_A) || (r_state == S_CHK_B);

    always_comb begin
        logic sel;
        w_found   = 1'b0;
        s_valid   = 1'b0;
        s_key     = '0;
        s_st      = '0;
        s_retry   = '0;
        s_due     = '0;
        s_backoff = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (w_walk) sel = (r_idx == IDXW'(e));
            else sel = w_valid[e] && (w_key[e] == r_key);
            if (!w_walk && sel) w_found = 1'b1;
            if (sel) begin
                s_valid   = s_valid | w_valid[e];
                s_key     = s_key | w_key[e];
                s_st      = s_st | w_st[e];
                s_retry   = s_retry | w_retry[e];
                s_due     = s_due | w_due[e];
                s_backoff = s_backoff | w_backoff[e];
            end
        end
    end

    // Ack evaluation on the matched entry.
    logic       w_ridx_ok;
    logic [2:0] w_cur;
    logic [2:0] w_to;
    logic       w_legal;
    logic       w_all_done;
    logic [7:0] w_fm;

    assign w_ridx_ok = (32'(r_ridx) < 32'(RECIPIENTS));
    assign w_to      = ST_DELIVERED + r_code;

    always_comb begin
        logic [2:0] st;
        w_cur      = ST_ABSENT;
        w_all_done = 1'b1;
        w_fm       = '0;
        for (int i = 0; i < RECIPIENTS; i++) begin
            if (i < 8 && i[2:0] == r_ridx) w_cur = s_st[i];
            st = (i < 8 && i[2:0] == r_ridx) ? w_to : s_st[i];
            if (st != ST_ABSENT && st != ST_DELIVERED && st != ST_READ) w_all_done = 1'b0;
            if (i < 8 && (s_st[i] == ST_ANNOUNCED || s_st[i] == ST_PENDING))
                w_fm[i[2:0]] = 1'b1;
        end
        if (w_cur == ST_PENDING)
            w_legal = (w_to == ST_DELIVERED) || (w_to == ST_FAILED) || (w_to == ST_BOUNCED);
        else if (w_cur == ST_DELIVERED)
            w_legal = (w_to == ST_READ);
        else
            w_legal = 1'b0;
    end

    // Check, first visit: due test, retry count and backoff product.
    logic [31:0] w_diff;
    assign w_diff = r_now - s_due;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK_A) begin
            r_hit     <= s_valid && !w_diff[31];
            r_retry_n <= (s_retry < RETRY_SAT) ? s_retry + 9'd1 : s_retry;
            r_exh     <= (((s_retry < RETRY_SAT) ? s_retry + 9'd1 : s_retry) > {1'b0, r_maxr});
            r_prod    <= 29'(s_backoff) * 29'(r_mult);
        end
    end

    // Check, second visit: new backoff and delay.
    logic [23:0] w_b;
    logic [23:0] w_delay;
    assign w_b     = (r_retry_n <= 9'd1) ? r_init :
                     ((|r_prod[28:24]) ? MAX24 : r_prod[23:0]);
    assign w_delay = (w_b > r_maxb) ? r_maxb : w_b;

    // Output and cell command logic.
    logic        w_emit;
    logic        w_stall;
    logic [3:0]  e_status;
    logic [15:0] e_key;
    logic [7:0]  e_fm;
    logic        e_rm;
    logic        e_last;

    always_comb begin
        w_emit   = 1'b0;
        w_stall  = 1'b0;
        e_status = RS_DONE;
        e_key    = r_key;
        e_fm     = '0;
        e_rm     = 1'b0;
        e_last   = 1'b1;
        w_cmd         = '0;
        w_cmd.op      = C_NOP;
        w_cmd.key     = r_key;
        w_cmd.slot    = 8'(r_idx);
        w_cmd.mask    = r_mask;
        w_cmd.ridx    = r_ridx;
        w_cmd.new_st  = w_to;
        w_cmd.done    = w_all_done;
        w_cmd.retry   = r_retry_n;
        w_cmd.due     = r_now + 32'(r_init);
        w_cmd.backoff = r_init;
        case (r_state)
            S_EXEC: begin
                if (r_op == OP_TRACK) begin
                    w_stall = !w_out_free;
                    w_emit  = w_out_free;
                    if (w_found) e_status = RS_DUPLICATE;
                    else if (w_taken[ENTRIES] == 1'b0) e_status = RS_FULL;
                    else begin
                        e_status = RS_TRACKED;
                        if (w_out_free) w_cmd.op = C_TRACK;
                    end
                end else if (r_op == OP_ACK) begin
                    w_stall = !w_out_free;
                    w_emit  = w_out_free;
                    if (!w_found) e_status = RS_UNK_MSG;
                    else if (!w_ridx_ok || w_cur == ST_ABSENT) e_status = RS_UNK_RCPT;
                    else if (r_code > 3'd3) e_status = RS_BAD_CODE;
                    else if (!w_legal) e_status = RS_ILLEGAL;
                    else begin
                        e_status = RS_APPLIED;
                        e_rm     = w_all_done;
                        if (w_out_free) w_cmd.op = C_ACK;
                    end
                end else if (r_op != OP_CHECK) begin
                    w_stall  = !w_out_free;
                    w_emit   = w_out_free;
                    e_status = RS_BAD_CODE;
                    e_key    = '0;
                end
            end
            S_CHK_B: begin
                if (r_hit && r_exh) begin
                    w_stall  = !w_out_free;
                    w_emit   = w_out_free;
                    e_status = RS_FAILED;
                    e_key    = s_key;
                    e_fm     = w_fm;
                    e_rm     = 1'b1;
                    e_last   = 1'b0;
                    if (w_out_free) w_cmd.op = C_EXHAUST;
                end else if (r_hit) begin
                    w_cmd.op      = C_RETRY;
                    w_cmd.backoff = w_b;
                    w_cmd.due     = r_now + 32'(w_delay);
                end
            end
            S_CHK_END: begin
                w_stall  = !w_out_free;
                w_emit   = w_out_free;
                e_status = RS_DONE;
                e_key    = '0;
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_accept) n_state = S_EXEC;
            S_EXEC: begin
                if (r_op == OP_CHECK) n_state = S_CHK_A;
                else if (!w_stall) n_state = S_IDLE;
            end
            S_CHK_A:   n_state = S_CHK_B;
            S_CHK_B: begin
                if (!w_stall) n_state = (r_idx == IDXW'(ENTRIES - 1)) ? S_CHK_END : S_CHK_A;
            end
            S_CHK_END: if (!w_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) r_idx <= '0;
            else if (r_state == S_CHK_B && !w_stall) r_idx <= r_idx + 1'b1;
            if (w_emit) r_ov <= 1'b1;
            else if (i_m_axis_tready) r_ov <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_axis_tdata[1:0];
            r_key  <= i_s_axis_tdata[17:2];
            r_mask <= i_s_axis_tdata[25:18];
            r_ridx <= i_s_axis_tdata[28:26];
            r_code <= i_s_axis_tdata[31:29];
            r_now  <= i_s_axis_tdata[63:32];
        end
        if (w_emit) begin
            r_o_status <= e_status;
            r_o_key    <= e_key;
            r_o_fm     <= e_fm;
            r_o_rm     <= e_rm;
            r_o_last   <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, r_o_rm, r_o_fm, r_o_key, r_o_status};
    assign o_m_axis_tlast  = r_o_last;

endmodule
`default_nettype wire

/* hdl/drt_checker.sv */
// Port-level checker for the delivery retry table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module drt_checker import drt_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    // A stalled result keeps its payload.
    `DRT_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && o_m_axis_tvalid)

    // Reset leaves no result pending.
    `DRT_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_m_axis_tvalid)

    // An accepted item keeps the block busy for the next cycle.
    `DRT_ASSERT_NEXT(a_busy, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // Only exhaustion reports are non-final, and they always remove the entry.
    `DRT_ASSERT_SAME(a_nonlast, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tdata[3:0] == RS_FAILED && o_m_axis_tdata[28])

endmodule

bind delivery_retry_table_top drt_checker u_drt_checker (.*);
`default_nettype wire
